@@ design/cdw_pkg.sv @@
// ----------------------------------------------------------------------------
// cdw_pkg
// Shared types, codes and the fixed Code 39 pattern table for the
// element width decoder.
// ----------------------------------------------------------------------------
package cdw_pkg;

    localparam int TABLE_ROWS        = 44;
    localparam int ELEMENTS_PER_CHAR = 9;

    localparam int WIDTH_W = 16;   // width_ticks
    localparam int NSUM_W  = 19;   // narrow_sum
    localparam int COUNT_W = 6;    // char_count, data_count
    localparam int CHAR_W  = 7;    // ASCII code
    localparam int PAT_W   = 9;    // wide pattern
    localparam int WCNT_W  = 4;    // wide_count
    localparam int IDX_W   = 4;    // element_index
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WIDTH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOST  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS   = 2'd2;

    localparam logic [5:0] WIDE_FACTOR_RESET = 6'd18;
    localparam logic [7:0] MIN_TICKS_RESET   = 8'd5;
    localparam logic [5:0] MAX_CHARS_RESET   = 6'd6;

    localparam int             STAR_ROW   = 39;
    localparam logic [CHAR_W-1:0] STAR_CHAR = 7'h2A;
    localparam logic [WCNT_W-1:0] DATA_WIDES = 4'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_CHAR = 3'd0,
        ST_OK   = 3'd1,
        ST_BAD  = 3'd2,
        ST_LONG = 3'd3,
        ST_OFF  = 3'd4
    } status_t;

    typedef struct packed {
        logic [5:0] wide_factor_tenths;
        logic [7:0] flicker_ticks;
        logic [5:0] char_limit;
    } cfg_t;

    typedef struct packed {
        status_t             status;
        logic [CHAR_W-1:0]   character;
        logic [COUNT_W-1:0]  data_count;
    } result_t;

    // ASCII code in [15:9], wide flags in [8:0] with the first element in bit 8
    localparam logic [15:0] PATTERN_ROM [TABLE_ROWS] = '{
        {7'h30, 9'b000110100}, {7'h31, 9'b100100001},
        {7'h32, 9'b001100001}, {7'h33, 9'b101100000},
        {7'h34, 9'b000110001}, {7'h35, 9'b100110000},
        {7'h36, 9'b001110000}, {7'h37, 9'b000100101},
        {7'h38, 9'b100100100}, {7'h39, 9'b001100100},
        {7'h41, 9'b100001001}, {7'h42, 9'b001001001},
        {7'h43, 9'b101001000}, {7'h44, 9'b000011001},
        {7'h45, 9'b100011000}, {7'h46, 9'b001011000},
        {7'h47, 9'b000001101}, {7'h48, 9'b100001100},
        {7'h49, 9'b001001100}, {7'h4A, 9'b000011100},
        {7'h4B, 9'b100000011}, {7'h4C, 9'b001000011},
        {7'h4D, 9'b101000010}, {7'h4E, 9'b000010011},
        {7'h4F, 9'b100010010}, {7'h50, 9'b001010010},
        {7'h51, 9'b000000111}, {7'h52, 9'b100000110},
        {7'h53, 9'b001000110}, {7'h54, 9'b000010110},
        {7'h55, 9'b110000001}, {7'h56, 9'b011000001},
        {7'h57, 9'b111000000}, {7'h58, 9'b010010001},
        {7'h59, 9'b110010000}, {7'h5A, 9'b011010000},
        {7'h2D, 9'b010000101}, {7'h2E, 9'b110000100},
        {7'h20, 9'b011000100}, {7'h2A, 9'b010010100},
        {7'h24, 9'b010101000}, {7'h2F, 9'b010100010},
        {7'h2B, 9'b010001010}, {7'h25, 9'b000101010}
    };

    localparam logic [PAT_W-1:0] STAR_PATTERN = PATTERN_ROM[STAR_ROW][PAT_W-1:0];

endpackage

@@ design/code39_element_width_decoder_core.sv @@
// ----------------------------------------------------------------------------
// code39_element_width_decoder_core
// Code 39 decoder fed with bar and space widths; emits characters and scan end.
// ----------------------------------------------------------------------------
// Latency: a result passes the input register and then the result register
// before it is on m_*.
// Throughput: one width per cycle while m_tready is high; the input register
// and the result register each hold one item, so a stalled result holds
// only the next item back.
// Reset (aresetn low, synchronous): scan idle, counters cleared, registers
// at wide factor 18 tenths, flicker floor 5 ticks, character limit 6.
module code39_element_width_decoder_core
    import cdw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [15:0] width_ticks
    input  logic [1:0]            s_tuser,    // [1:0] func

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,    // [6:0] character, [12:7] data_count
    output logic [2:0]            m_tuser,    // [2:0] status

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               advance;
    logic               res_valid;
    result_t            res;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wide_factor_tenths <= WIDE_FACTOR_RESET;
            cfg_reg.flicker_ticks      <= MIN_TICKS_RESET;
            cfg_reg.char_limit         <= MAX_CHARS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WIDE_FACTOR: cfg_reg.wide_factor_tenths <= cfg_data[5:0];
                REG_MIN_TICKS:   cfg_reg.flicker_ticks      <= cfg_data;
                REG_MAX_CHARS:   cfg_reg.char_limit         <= cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            func_reg  <= s_tuser;
            width_reg <= s_tdata;
        end
    end

    cdw_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .func        (func_reg),
        .width_ticks (width_reg),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b0, out_reg.data_count, out_reg.character};

endmodule

@@ design/cdw_match.sv @@
// ----------------------------------------------------------------------------
// cdw_match
// Parallel compare of a nine-element wide pattern against the Code 39 table.
// ----------------------------------------------------------------------------
module cdw_match
    import cdw_pkg::*;
(
    input  logic [PAT_W-1:0]  pattern,
    output logic              hit,
    output logic [CHAR_W-1:0] character
);

    // scan from the bottom so the first matching row wins
    always_comb begin
        hit       = 1'b0;
        character = '0;
        for (int r = TABLE_ROWS - 1; r >= 0; r--) begin
            if (PATTERN_ROM[r][PAT_W-1:0] == pattern) begin
                hit       = 1'b1;
                character = PATTERN_ROM[r][15:PAT_W];
            end
        end
    end

endmodule

@@ design/cdw_scan.sv @@
// ----------------------------------------------------------------------------
// cdw_scan
// Scan state and the per-width step: start character sum, narrow/wide
// classification, character match and result selection.
// ----------------------------------------------------------------------------
module cdw_scan
    import cdw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [FUNC_W-1:0]  func,
    input  logic [WIDTH_W-1:0] width_ticks,
    input  cfg_t               cfg,
    output logic               res_valid,
    output result_t            res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    logic [PAT_W-1:0]    pat_reg,     pat_next;
    logic [WCNT_W-1:0]   wcnt_reg,    wcnt_next;
    logic [NSUM_W-1:0]   nsum_reg,    nsum_next;
    logic [COUNT_W-1:0]  ccnt_reg,    ccnt_next;

    logic [21:0]         lhs;
    logic [24:0]         rhs;
    logic                wide;
    logic [PAT_W-1:0]    pat_shift;
    logic [WCNT_W-1:0]   wcnt_inc;
    logic [IDX_W-1:0]    star_pos;
    logic                last_elem;
    logic                hit;
    logic [CHAR_W-1:0]   match_char;

    // 60*w as 64w - 4w
    assign lhs       = {width_ticks, 6'b0} - {4'b0, width_ticks, 2'b0};
    assign rhs       = {19'b0, cfg.wide_factor_tenths} * {6'b0, nsum_reg};
    assign wide      = {3'b0, lhs} > rhs;
    assign pat_shift = {pat_reg[PAT_W-2:0], wide};
    assign wcnt_inc  = wcnt_reg + {{(WCNT_W-1){1'b0}}, wide};
    assign star_pos  = IDX_W'(PAT_W - 1) - idx_reg;
    assign last_elem = idx_reg == IDX_W'(ELEMENTS_PER_CHAR - 1);

    cdw_match u_match (
        .pattern   (pat_shift),
        .hit       (hit),
        .character (match_char)
    );

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        pat_next   = pat_reg;
        wcnt_next  = wcnt_reg;
        nsum_next  = nsum_reg;
        ccnt_next  = ccnt_reg;
        res_valid  = 1'b0;
        res.status    = ST_CHAR;
        res.character = '0;

        if (step) begin
            case (func)
                FUNC_START: begin
                    phase_next = PH_START;
                    idx_next   = '0;
                    pat_next   = '0;
                    wcnt_next  = '0;
                    nsum_next  = '0;
                    ccnt_next  = '0;
                end
                FUNC_LOST: begin
                    if (phase_reg != PH_IDLE) begin
                        phase_next = PH_IDLE;
                        idx_next   = '0;
                        pat_next   = '0;
                        wcnt_next  = '0;
                        res_valid  = 1'b1;
                        res.status = ST_OFF;
                    end
                end
                FUNC_WIDTH: begin
                    case (phase_reg)
                        PH_START: begin
                            // only narrow positions of the start character feed the sum
                            if (!STAR_PATTERN[star_pos])
                                nsum_next = nsum_reg + NSUM_W'(width_ticks);
                            if (last_elem) begin
                                phase_next = PH_DATA;
                                idx_next   = '0;
                                pat_next   = '0;
                                wcnt_next  = '0;
                            end else begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                        PH_DATA: begin
                            // drop flicker
                            if (width_ticks >= WIDTH_W'(cfg.flicker_ticks)) begin
                                if (!last_elem) begin
                                    idx_next  = idx_reg + 1'b1;
                                    pat_next  = pat_shift;
                                    wcnt_next = wcnt_inc;
                                end else begin
                                    phase_next = PH_IDLE;
                                    idx_next   = '0;
                                    pat_next   = '0;
                                    wcnt_next  = '0;
                                    res_valid  = 1'b1;
                                    if (!hit) begin
                                        res.status = ST_BAD;
                                    end else if (match_char == STAR_CHAR) begin
                                        res.status = ST_OK;
                                    end else if (wcnt_inc != DATA_WIDES) begin
                                        res.status = ST_BAD;
                                    end else if (ccnt_reg >= cfg.char_limit) begin
                                        res.status = ST_LONG;
                                    end else begin
                                        res.status    = ST_CHAR;
                                        res.character = match_char;
                                        ccnt_next     = ccnt_reg + 1'b1;
                                        phase_next    = PH_DATA;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        res.data_count = ccnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            pat_reg   <= '0;
            wcnt_reg  <= '0;
            nsum_reg  <= '0;
            ccnt_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            pat_reg   <= pat_next;
            wcnt_reg  <= wcnt_next;
            nsum_reg  <= nsum_next;
            ccnt_reg  <= ccnt_next;
        end
    end

endmodule

@@ tb/sv/code39_element_width_decoder_core_test.sv @@
// ----------------------------------------------------------------------------
// code39_element_width_decoder_core_test
// Self-checking bench for the Code 39 element width decoder. Scans of bar and
// space widths, with flicker and noise mixed in, go through the width stream
// under random idle bursts on both sides. A cycle-free predictor built in this
// file tracks the scan state and checks every result transfer in order.
// ----------------------------------------------------------------------------
module code39_element_width_decoder_core_test;
    import cdw_pkg::*;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 250;

    typedef enum logic [1:0] {
        SCAN_IDLE  = 2'd0,
        SCAN_START = 2'd1,
        SCAN_DATA  = 2'd2
    } scan_phase_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [WIDTH_W-1:0] width_ticks;
    } width_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    code39_element_width_decoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // predictor state and its copy of the registers
    cfg_t                decoder_cfg = '{wide_factor_tenths: WIDE_FACTOR_RESET,
                                         flicker_ticks: MIN_TICKS_RESET,
                                         char_limit: MAX_CHARS_RESET};
    scan_phase_t         scan_phase  = SCAN_IDLE;
    logic [IDX_W-1:0]    elem_idx    = '0;
    logic [PAT_W-1:0]    wide_bits   = '0;
    logic [WCNT_W-1:0]   wides_seen  = '0;
    logic [NSUM_W-1:0]   narrow_total = '0;
    logic [COUNT_W-1:0]  chars_done  = '0;

    width_item_t pending_widths[$];
    result_t     decoded_q[$];
    width_item_t next_width;
    int unsigned queued_total = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    bit          s_took       = 1'b0;
    bit          calm         = 1'b0;
    int unsigned s_gap        = 0;
    int unsigned m_gap        = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    function automatic void clear_char();
        scan_phase = SCAN_IDLE;
        elem_idx   = '0;
        wide_bits  = '0;
        wides_seen = '0;
    endfunction

    // Advance the scan by one item; returns 1 when a result is due.
    function automatic bit decode_width(input logic [FUNC_W-1:0] fn,
                                        input logic [WIDTH_W-1:0] w,
                                        output result_t res);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic        is_wide;
        int          row;
        logic [WCNT_W-1:0] wc;
        logic [CHAR_W-1:0] ch;
        res = '{status: ST_CHAR, character: '0, data_count: '0};
        if (fn == FUNC_START) begin
            clear_char();
            scan_phase   = SCAN_START;
            narrow_total = '0;
            chars_done   = '0;
            return 1'b0;
        end
        if (fn == FUNC_LOST) begin
            if (scan_phase == SCAN_IDLE) return 1'b0;
            clear_char();
            res.status     = ST_OFF;
            res.data_count = chars_done;
            return 1'b1;
        end
        if (fn != FUNC_WIDTH || scan_phase == SCAN_IDLE) return 1'b0;

        if (scan_phase == SCAN_START) begin
            // only the narrow positions of the start character set the threshold
            if (!STAR_PATTERN[PAT_W-1-elem_idx]) narrow_total = narrow_total + w;
            elem_idx = elem_idx + 1'b1;
            if (elem_idx >= ELEMENTS_PER_CHAR) begin
                scan_phase = SCAN_DATA;
                elem_idx   = '0;
                wide_bits  = '0;
                wides_seen = '0;
            end
            return 1'b0;
        end

        if (w < decoder_cfg.flicker_ticks) return 1'b0;
        lhs = 32'(w) * 32'd60;
        rhs = 32'(decoder_cfg.wide_factor_tenths) * 32'(narrow_total);
        is_wide    = (lhs > rhs);
        wide_bits  = {wide_bits[PAT_W-2:0], is_wide};
        wides_seen = wides_seen + is_wide;
        elem_idx   = elem_idx + 1'b1;
        if (elem_idx < ELEMENTS_PER_CHAR) return 1'b0;

        row = TABLE_ROWS;
        for (int i = 0; i < TABLE_ROWS; i++) begin
            if (row == TABLE_ROWS && PATTERN_ROM[i][PAT_W-1:0] == wide_bits) row = i;
        end
        wc = wides_seen;
        clear_char();
        res.data_count = chars_done;
        if (row == TABLE_ROWS) begin
            res.status = ST_BAD;
            return 1'b1;
        end
        ch = PATTERN_ROM[row][15:9];
        if (ch == STAR_CHAR) begin
            res.status = ST_OK;
        end else if (wc != DATA_WIDES) begin
            res.status = ST_BAD;
        end else if (chars_done >= decoder_cfg.char_limit) begin
            res.status = ST_LONG;
        end else begin
            chars_done     = chars_done + 1'b1;
            scan_phase     = SCAN_DATA;
            res.character  = ch;
            res.data_count = chars_done;
        end
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        if (mismatches < 10)
            $display("mismatch %0s: expected %0d, got %0d at %0t", what, want, got, $time);
        mismatches++;
    endtask

    // sample both channels at the rising edge; check results, then predict
    always @(posedge aclk) begin
        result_t want;
        result_t fresh;
        s_took = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    note_mismatch("unexpected result, status", -1, m_tuser);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tuser != want.status)
                        note_mismatch("status", want.status, m_tuser);
                    if (m_tdata[6:0] != want.character)
                        note_mismatch("character", want.character, m_tdata[6:0]);
                    if (m_tdata[12:7] != want.data_count)
                        note_mismatch("data_count", want.data_count, m_tdata[12:7]);
                    if (m_tdata[15:13] != 3'd0)
                        note_mismatch("tdata pad", 0, m_tdata[15:13]);
                end
            end
            if (s_took && decode_width(s_tuser, s_tdata, fresh))
                decoded_q.push_back(fresh);
        end
    end

    // width stream driver
    always @(negedge aclk) begin
        if (!s_tvalid || s_took) begin
            if (s_gap != 0) begin
                s_gap    <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_widths.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
                s_gap    <= $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end else if (pending_widths.size() != 0) begin
                next_width = pending_widths.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_width.func;
                s_tdata  <= next_width.width_ticks;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver; one long hold-off while widths are still queued
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && results_seen >= 12 && pending_widths.size() >= 40) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else if (m_gap != 0) begin
            m_gap    <= m_gap - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            m_gap    <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_item(input logic [FUNC_W-1:0] fn, input int unsigned w);
        pending_widths.push_back('{func: fn, width_ticks: WIDTH_W'(w)});
        queued_total++;
    endtask

    // one character of nine widths, first element from the top bit; data characters may carry extra flicker widths
    task automatic push_char(input logic [PAT_W-1:0] pat, input int unsigned n,
                             input int unsigned wide_w, input bit is_data);
        int unsigned mt;
        int unsigned w;
        mt = decoder_cfg.flicker_ticks;
        for (int i = PAT_W - 1; i >= 0; i--) begin
            if (is_data && mt > 0 && $urandom_range(0, 11) == 0)
                push_item(FUNC_WIDTH, $urandom_range(0, mt - 1));
            if (pat[i]) w = wide_w;
            else if (is_data) w = n - $urandom_range(0, (n - mt) / 4);
            else w = n;
            push_item(FUNC_WIDTH, w);
        end
    endtask

    task automatic push_scan();
        int unsigned mt;
        int unsigned n;
        int unsigned wide_w;
        int unsigned k;
        int unsigned ending;
        int unsigned row;
        logic [PAT_W-1:0] pat;
        mt = decoder_cfg.flicker_ticks;
        if ($urandom_range(0, 9) == 0) n = mt + $urandom_range(2, 9000);
        else n = mt + $urandom_range(2, 200);
        wide_w = (n * decoder_cfg.wide_factor_tenths) / 10 + 1 + $urandom_range(0, n);
        if (wide_w > 65535) wide_w = 65535;
        push_item(FUNC_START, $urandom);
        push_char(STAR_PATTERN, n, wide_w, 1'b0);
        k = $urandom_range(0, decoder_cfg.char_limit + 1);
        if (k > 8) k = $urandom_range(0, 8);
        repeat (k) begin
            if ($urandom_range(0, 9) == 0) begin
                pat = PAT_W'($urandom);
            end else begin
                row = $urandom_range(0, TABLE_ROWS - 2);
                if (row >= STAR_ROW) row++;
                pat = PATTERN_ROM[row][PAT_W-1:0];
            end
            push_char(pat, n, wide_w, 1'b1);
        end
        ending = $urandom_range(0, 19);
        if (ending < 12) begin
            push_char(STAR_PATTERN, n, wide_w, 1'b1);
        end else if (ending < 15) begin
            push_item(FUNC_LOST, $urandom);
        end else if (ending < 18) begin
            // lose the line in mid-character
            repeat ($urandom_range(1, 8)) push_item(FUNC_WIDTH, n);
            push_item(FUNC_LOST, $urandom);
        end
        // otherwise leave the scan open; the next start drops it
    endtask

    task automatic push_random(input int unsigned target);
        int unsigned first;
        first = queued_total;
        while (queued_total - first < target) begin
            if ($urandom_range(0, 9) < 8) push_scan();
            else repeat ($urandom_range(1, 3))
                push_item(FUNC_W'($urandom_range(0, 3)), $urandom);
        end
    endtask

    task automatic drain_and_settle();
        while (pending_widths.size() != 0 || s_tvalid || decoded_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_WIDE_FACTOR: decoder_cfg.wide_factor_tenths = val[5:0];
            REG_MIN_TICKS:   decoder_cfg.flicker_ticks      = val;
            REG_MAX_CHARS:   decoder_cfg.char_limit         = val[5:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int unsigned f, input int unsigned mt, input int unsigned mx);
        write_reg(REG_WIDE_FACTOR, 8'(f));
        write_reg(REG_MIN_TICKS, 8'(mt));
        write_reg(REG_MAX_CHARS, 8'(mx));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ignored items while idle
        push_item(FUNC_WIDTH, 16'hFFFF);
        push_item(FUNC_LOST, 16'h0000);
        push_item(FUNC_UNUSED, 16'hA5A5);
        // start: narrow 10, wide 30, so widths above 18 are wide at factor 18
        push_item(FUNC_START, 16'h0000);
        push_char(STAR_PATTERN, 10, 30, 1'b0);
        // 'A' on the threshold edge, with flicker and an unused func in between
        push_item(FUNC_WIDTH, 19);
        push_item(FUNC_WIDTH, 0);
        push_item(FUNC_WIDTH, 18);
        push_item(FUNC_WIDTH, 4);
        push_item(FUNC_UNUSED, 16'h5A5A);
        for (int i = PAT_W - 3; i >= 0; i--) begin
            push_item(FUNC_WIDTH, PATTERN_ROM[10][i] ? 19 : 18);
        end
        push_char(STAR_PATTERN, 10, 19, 1'b1);
        push_random(130);
        drain_and_settle();

        set_regs(10, 0, 0);
        push_random(110);
        drain_and_settle();

        set_regs(40, 255, 63);
        write_reg(REG_UNUSED, 8'hFF);
        push_random(110);
        drain_and_settle();

        set_regs(0, 1, 3);
        push_random(60);
        drain_and_settle();

        set_regs(63, 20, 10);
        push_random(100);
        drain_and_settle();

        calm = 1'b1;
        set_regs($urandom_range(10, 40), $urandom_range(0, 60), $urandom_range(0, 12));
        push_random(110);
        drain_and_settle();

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("PASS code39_element_width_decoder_core");
        end else begin
            $display("FAIL code39_element_width_decoder_core");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL code39_element_width_decoder_core");
        $finish;
    end

endmodule
